// ===== rtl/md5_pkg.sv =====
// MD5 byte-stream hasher: shared types, constants and round tables.
// Used by the controller, the datapath and the top level.
`default_nettype none

package md5_pkg;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  localparam logic [7:0] PadByte = 8'h80;
  localparam logic [5:0] LenStart = 6'd56;
  localparam logic [5:0] FillLast = 6'd63;
  localparam logic [5:0] RoundLast = 6'd63;

  localparam int unsigned LaneCount = 4;
  localparam int unsigned WordDepth = 16;

  localparam logic [31:0] RoundAdd [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] RotAmount [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  typedef enum logic [3:0] {
    StIdle,
    StPad80,
    StPadZero,
    StPadLen,
    StCompPre,
    StCompRun,
    StCompAdd,
    StDone
  } md5_state_e;

  typedef enum logic [1:0] {
    WselData,
    WselPad,
    WselZero,
    WselLen
  } md5_wsel_e;

  typedef struct packed {
    logic      wr_en;
    md5_wsel_e wr_sel;
    logic      load_work;
    logic      round_en;
    logic      add_chain;
    logic      load_digest;
  } md5_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic fill_at_len;
    logic round_last;
    logic out_busy;
  } md5_sts_t;

  // message word used by a given round
  function automatic logic [3:0] msg_pick(input logic [5:0] round);
    logic [3:0] idx;
    logic [3:0] res;
    idx = round[3:0];
    unique case (round[5:4])
      2'd0: res = idx;
      2'd1: res = idx * 4'd5 + 4'd1;
      2'd2: res = idx * 4'd3 + 4'd5;
      2'd3: res = idx * 4'd7;
      default: res = idx;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/md5_if.sv =====
// Handshake channels of the MD5 hasher: byte input and digest output.
// Depends on nothing but the valid/ready convention.
`default_nettype none

interface md5_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       is_last;

  modport source (output valid, data_byte, has_byte, is_last, input ready);
  modport sink (input valid, data_byte, has_byte, is_last, output ready);
endinterface

interface md5_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_half;
  logic        half_index;
  logic        last_of_run;

  modport source (output valid, digest_half, half_index, last_of_run, input ready);
  modport sink (input valid, digest_half, half_index, last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/md5_byte_stream_hasher.sv =====
// MD5 byte-stream hasher, top level.
// Depends on md5_pkg, md5_if, md5_ram, md5_ctrl and md5_dpath.
//
// Usage:
//   in_i carries one beat per message byte (has_byte) and marks the end of
//   a message with is_last; a beat with has_byte low and is_last high
//   finishes the empty message. out_o returns two 64-bit beats per message,
//   digest bytes 0..7 then 8..15 (last_of_run high on the second).
// Throughput: a byte beat is taken every cycle until a 64-byte block fills;
//   the block then runs (load, 64 rounds at one round per cycle, chain add)
//   with in_i.ready low. The single round unit limits the throughput.
// Finish: after the last beat, padding writes one byte per cycle outside
//   block runs, with a turn at byte 56 for the length; one or two block runs
//   follow, then the output register is loaded and the digest becomes valid.
// Stall: the digest register holds both beats while out_o.ready is low;
//   bytes of the next message keep being taken meanwhile, and only the next
//   digest hand-off waits until both beats have left.
// Reset: the chaining value returns to the MD5 initial value, counters clear,
//   no output beat is pending.
`default_nettype none

module md5_byte_stream_hasher (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  md5_in_if.sink    in_i,
  md5_out_if.source out_o
);

  md5_pkg::md5_cmd_t cmd;
  md5_pkg::md5_sts_t sts;

  md5_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_has_byte_i (in_i.has_byte),
    .in_is_last_i  (in_i.is_last),
    .in_ready_o    (in_i.ready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  md5_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .data_byte_i   (in_i.data_byte),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .digest_half_o (out_o.digest_half),
    .half_index_o  (out_o.half_index),
    .last_of_run_o (out_o.last_of_run)
  );

`ifndef SYNTHESIS
  a_second_half_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.half_index) |=> (out_o.valid && out_o.half_index))
    else $error("second digest beat missing");

  a_digest_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_digest |-> !sts.out_busy)
    else $error("digest loaded over a pending beat");

  a_no_write_in_rounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.round_en |-> (!cmd.wr_en && !in_i.ready))
    else $error("buffer write during compression");
`endif

endmodule

`default_nettype wire

// ===== rtl/md5_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module md5_ram #(
  parameter int unsigned DataWidth = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [$clog2(Depth)-1:0]     waddr_i,
  input  wire logic [DataWidth-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0]     raddr_i,
  output logic      [DataWidth-1:0]         rdata_o
);

  logic [DataWidth-1:0] mem_q [Depth];
  logic [DataWidth-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/md5_ctrl.sv =====
// Sequencer of the MD5 hasher: byte intake, padding, compression and digest hand-off.
// Depends on md5_pkg; drives md5_dpath through the command struct.
`default_nettype none

module md5_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_has_byte_i,
  input  wire logic              in_is_last_i,
  output logic                   in_ready_o,
  input  wire md5_pkg::md5_sts_t sts_i,
  output md5_pkg::md5_cmd_t      cmd_o
);

  md5_pkg::md5_state_e state_q, state_d;
  md5_pkg::md5_state_e resume_q, resume_d;
  md5_pkg::md5_state_e after_in;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= md5_pkg::StIdle;
      resume_q <= md5_pkg::StIdle;
    end else begin
      state_q  <= state_d;
      resume_q <= resume_d;
    end
  end

  assign after_in = in_is_last_i ? md5_pkg::StPad80 : md5_pkg::StIdle;

  always_comb begin
    state_d  = state_q;
    resume_d = resume_q;
    unique case (state_q)
      md5_pkg::StIdle: begin
        if (in_valid_i) begin
          if (in_has_byte_i && sts_i.fill_last) begin
            state_d  = md5_pkg::StCompPre;
            resume_d = after_in;
          end else begin
            state_d = after_in;
          end
        end
      end
      md5_pkg::StPad80: begin
        if (sts_i.fill_last) begin
          state_d  = md5_pkg::StCompPre;
          resume_d = md5_pkg::StPadZero;
        end else begin
          state_d = md5_pkg::StPadZero;
        end
      end
      md5_pkg::StPadZero: begin
        if (sts_i.fill_at_len) begin
          state_d = md5_pkg::StPadLen;
        end else if (sts_i.fill_last) begin
          state_d  = md5_pkg::StCompPre;
          resume_d = md5_pkg::StPadZero;
        end
      end
      md5_pkg::StPadLen: begin
        if (sts_i.fill_last) begin
          state_d  = md5_pkg::StCompPre;
          resume_d = md5_pkg::StDone;
        end
      end
      md5_pkg::StCompPre: state_d = md5_pkg::StCompRun;
      md5_pkg::StCompRun: begin
        if (sts_i.round_last) begin
          state_d = md5_pkg::StCompAdd;
        end
      end
      md5_pkg::StCompAdd: state_d = resume_q;
      md5_pkg::StDone: begin
        if (!sts_i.out_busy) begin
          state_d = md5_pkg::StIdle;
        end
      end
      default: state_d = md5_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.wr_sel = md5_pkg::WselData;
    in_ready_o = 1'b0;
    unique case (state_q)
      md5_pkg::StIdle: begin
        in_ready_o   = 1'b1;
        cmd_o.wr_en  = in_valid_i && in_has_byte_i;
      end
      md5_pkg::StPad80: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = md5_pkg::WselPad;
      end
      md5_pkg::StPadZero: begin
        cmd_o.wr_en  = !sts_i.fill_at_len;
        cmd_o.wr_sel = md5_pkg::WselZero;
      end
      md5_pkg::StPadLen: begin
        cmd_o.wr_en  = 1'b1;
        cmd_o.wr_sel = md5_pkg::WselLen;
      end
      md5_pkg::StCompPre: cmd_o.load_work = 1'b1;
      md5_pkg::StCompRun: cmd_o.round_en = 1'b1;
      md5_pkg::StCompAdd: cmd_o.add_chain = 1'b1;
      md5_pkg::StDone: cmd_o.load_digest = !sts_i.out_busy;
      default: cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/md5_dpath.sv =====
// Datapath of the MD5 hasher: block buffer lanes, counters, round unit, chain and digest.
// Depends on md5_pkg and md5_ram; commanded by md5_ctrl.
`default_nettype none

module md5_dpath (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [7:0]        data_byte_i,
  input  wire md5_pkg::md5_cmd_t cmd_i,
  output md5_pkg::md5_sts_t      sts_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [63:0]            digest_half_o,
  output logic                   half_index_o,
  output logic                   last_of_run_o
);

  localparam int unsigned WordAw = $clog2(md5_pkg::WordDepth);

  logic [5:0]   fill_q, fill_d;
  logic [60:0]  byte_cnt_q, byte_cnt_d;
  logic [5:0]   round_q, round_d;
  logic [31:0]  chain_q [4];
  logic [31:0]  chain_d [4];
  logic [31:0]  a_q, b_q, c_q, d_q;
  logic [31:0]  a_d, b_d, c_d, d_d;
  logic [127:0] digest_q, digest_d;
  logic         busy_q, busy_d;
  logic         half_q, half_d;

  logic [7:0]   wbyte;
  logic [63:0]  bit_len;
  logic [31:0]  msg_word;
  logic [WordAw-1:0] raddr;
  logic [5:0]   round_next;
  logic [31:0]  mix;
  logic [31:0]  sum;
  logic [63:0]  rot_wide;
  logic [4:0]   rot_amt;

  assign bit_len = {byte_cnt_q, 3'b000};

  always_comb begin
    case (cmd_i.wr_sel)
      md5_pkg::WselData: wbyte = data_byte_i;
      md5_pkg::WselPad:  wbyte = md5_pkg::PadByte;
      md5_pkg::WselZero: wbyte = 8'h00;
      md5_pkg::WselLen:  wbyte = bit_len[{fill_q[2:0], 3'b000} +: 8];
      default:           wbyte = 8'h00;
    endcase
  end

  assign round_next = cmd_i.load_work ? 6'd0 : round_q + 6'd1;
  assign raddr      = md5_pkg::msg_pick(round_next);

  for (genvar k = 0; k < md5_pkg::LaneCount; k++) begin : g_lane
    md5_ram #(
      .DataWidth (8),
      .Depth     (md5_pkg::WordDepth)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (cmd_i.wr_en && (fill_q[1:0] == 2'(k))),
      .waddr_i (fill_q[5:2]),
      .wdata_i (wbyte),
      .raddr_i (raddr),
      .rdata_o (msg_word[8*k +: 8])
    );
  end

  always_comb begin
    unique case (round_q[5:4])
      2'd0: mix = (b_q & c_q) | (~b_q & d_q);
      2'd1: mix = (d_q & b_q) | (~d_q & c_q);
      2'd2: mix = b_q ^ c_q ^ d_q;
      2'd3: mix = c_q ^ (b_q | ~d_q);
      default: mix = '0;
    endcase
  end

  assign rot_amt  = md5_pkg::RotAmount[{round_q[5:4], round_q[1:0]}];
  assign sum      = a_q + mix + md5_pkg::RoundAdd[round_q] + msg_word;
  assign rot_wide = {sum, sum} << rot_amt;

  always_comb begin
    fill_d     = fill_q;
    byte_cnt_d = byte_cnt_q;
    round_d    = round_q;
    chain_d    = chain_q;
    a_d        = a_q;
    b_d        = b_q;
    c_d        = c_q;
    d_d        = d_q;
    digest_d   = digest_q;
    busy_d     = busy_q;
    half_d     = half_q;

    if (cmd_i.wr_en) begin
      fill_d = fill_q + 6'd1;
      if (cmd_i.wr_sel == md5_pkg::WselData) begin
        byte_cnt_d = byte_cnt_q + 61'd1;
      end
    end
    if (cmd_i.load_work) begin
      a_d     = chain_q[0];
      b_d     = chain_q[1];
      c_d     = chain_q[2];
      d_d     = chain_q[3];
      round_d = 6'd0;
    end
    if (cmd_i.round_en) begin
      a_d     = d_q;
      d_d     = c_q;
      c_d     = b_q;
      b_d     = b_q + rot_wide[63:32];
      round_d = round_q + 6'd1;
    end
    if (cmd_i.add_chain) begin
      chain_d[0] = chain_q[0] + a_q;
      chain_d[1] = chain_q[1] + b_q;
      chain_d[2] = chain_q[2] + c_q;
      chain_d[3] = chain_q[3] + d_q;
    end
    if (out_valid_o && out_ready_i) begin
      half_d = !half_q;
      busy_d = !half_q;
    end
    if (cmd_i.load_digest) begin
      digest_d   = {chain_q[3], chain_q[2], chain_q[1], chain_q[0]};
      busy_d     = 1'b1;
      half_d     = 1'b0;
      chain_d[0] = md5_pkg::InitA;
      chain_d[1] = md5_pkg::InitB;
      chain_d[2] = md5_pkg::InitC;
      chain_d[3] = md5_pkg::InitD;
      byte_cnt_d = '0;
      fill_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      byte_cnt_q <= '0;
      round_q    <= '0;
      chain_q[0] <= md5_pkg::InitA;
      chain_q[1] <= md5_pkg::InitB;
      chain_q[2] <= md5_pkg::InitC;
      chain_q[3] <= md5_pkg::InitD;
      busy_q     <= 1'b0;
      half_q     <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      byte_cnt_q <= byte_cnt_d;
      round_q    <= round_d;
      chain_q    <= chain_d;
      busy_q     <= busy_d;
      half_q     <= half_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q      <= a_d;
    b_q      <= b_d;
    c_q      <= c_d;
    d_q      <= d_d;
    digest_q <= digest_d;
  end

  assign sts_o.fill_last   = (fill_q == md5_pkg::FillLast);
  assign sts_o.fill_at_len = (fill_q == md5_pkg::LenStart);
  assign sts_o.round_last  = (round_q == md5_pkg::RoundLast);
  assign sts_o.out_busy    = busy_q;

  assign out_valid_o   = busy_q;
  assign digest_half_o = half_q ? digest_q[127:64] : digest_q[63:0];
  assign half_index_o  = half_q;
  assign last_of_run_o = half_q;

endmodule

`default_nettype wire
